// ===== design/rsed_pkg.sv =====
// ----------------------------------------------------------------------------
// rsed_pkg: shared types and constants
// Field widths, queue sizes and the records passed between the front part
// and the back part of the rise step event detector.
// ----------------------------------------------------------------------------
package rsed_pkg;

  localparam int unsigned TimeBits  = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned SizeBits  = 32;
  localparam int unsigned CountBits = 32;
  localparam int unsigned SumBits   = 48;

  // Event queue between front and back
  localparam int unsigned EvqDepth   = 4;
  localparam int unsigned EvqPtrBits = $clog2(EvqDepth);

  // Result buffer in the back part
  localparam int unsigned ObufDepth   = 2;
  localparam int unsigned ObufPtrBits = $clog2(ObufDepth);

  // One finished glitch, as found by the front part
  typedef struct packed {
    logic [TimeBits-1:0] start_time;
    logic [TimeBits-1:0] rise_time;
    logic [SizeBits-1:0] size;
    logic [TimeBits-1:0] wait_time;
  } event_t;

  // One result request, with running statistics
  typedef struct packed {
    logic [TimeBits-1:0]  start_time;
    logic [TimeBits-1:0]  rise_time;
    logic [SizeBits-1:0]  size;
    logic [TimeBits-1:0]  wait_time;
    logic [CountBits-1:0] count;
    logic [SizeBits-1:0]  size_min;
    logic [SizeBits-1:0]  size_max;
    logic [SumBits-1:0]   size_sum;
  } result_t;

  // Queue handshake seen by the consumer side
  typedef struct packed {
    logic empty;
    logic pop;
  } qpop_t;

endpackage

// ===== design/rsed_front.sv =====
// ----------------------------------------------------------------------------
// rsed_front: sample tracker and rise classifier
// Keeps the previous sample, follows the rise phase, checks the size of each
// finished rise against the threshold and emits glitch events.
// ----------------------------------------------------------------------------
module rsed_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rsed_pkg::SizeBits-1:0]    cfg_wdata_i,
  input  logic                             accept_i,
  input  logic [rsed_pkg::TimeBits-1:0]    sample_time_i,
  input  logic signed [rsed_pkg::ValueBits-1:0] sample_value_i,
  output logic                             ev_push_o,
  output rsed_pkg::event_t                 ev_o
);
  import rsed_pkg::*;

  logic [SizeBits-1:0]  min_size_q;
  logic                 have_prev_q;
  logic [TimeBits-1:0]  prev_time_q;
  logic signed [ValueBits-1:0] prev_value_q;
  logic                 in_rise_q;
  logic [TimeBits-1:0]  start_time_q;
  logic [ValueBits-1:0] start_value_q;
  logic                 seen_first_q;
  logic [TimeBits-1:0]  last_time_q;

  logic                 up;
  logic                 down;
  logic                 rise_end;
  logic [ValueBits-1:0] size;
  logic                 is_glitch;

  // Classify the slope against the previous sample
  assign up       = sample_value_i > prev_value_q;
  assign down     = sample_value_i < prev_value_q;
  assign rise_end = accept_i && have_prev_q && in_rise_q && down;
  assign size     = ValueBits'(prev_value_q) - start_value_q;
  assign is_glitch = size > min_size_q;

  // Emit an event for every glitch after the first
  assign ev_push_o        = rise_end && is_glitch && seen_first_q;
  assign ev_o.start_time  = start_time_q;
  assign ev_o.rise_time   = prev_time_q - start_time_q;
  assign ev_o.size        = SizeBits'(size);
  assign ev_o.wait_time   = start_time_q - last_time_q;

  // Hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= '0;
    end else if (cfg_we_i) begin
      min_size_q <= cfg_wdata_i;
    end
  end

  // Advance the tracker on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q   <= 1'b0;
      prev_time_q   <= '0;
      prev_value_q  <= '0;
      in_rise_q     <= 1'b0;
      start_time_q  <= '0;
      start_value_q <= '0;
      seen_first_q  <= 1'b0;
      last_time_q   <= '0;
    end else if (accept_i) begin
      have_prev_q  <= 1'b1;
      prev_time_q  <= sample_time_i;
      prev_value_q <= sample_value_i;
      if (have_prev_q) begin
        if (!in_rise_q) begin
          if (up) begin
            in_rise_q     <= 1'b1;
            start_time_q  <= prev_time_q;
            start_value_q <= ValueBits'(prev_value_q);
          end
        end else if (down) begin
          in_rise_q <= 1'b0;
          if (is_glitch) begin
            seen_first_q <= 1'b1;
            last_time_q  <= start_time_q;
          end
        end
      end
    end
  end

endmodule

// ===== design/rsed_evq.sv =====
// ----------------------------------------------------------------------------
// rsed_evq: glitch event queue
// Short first-in first-out queue that decouples the classifier from the
// statistics stage.
// ----------------------------------------------------------------------------
module rsed_evq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsed_pkg::event_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output rsed_pkg::event_t  data_o
);
  import rsed_pkg::*;

  event_t                slot_q [EvqDepth];
  logic [EvqPtrBits-1:0] wr_ptr_q;
  logic [EvqPtrBits-1:0] rd_ptr_q;
  logic [EvqPtrBits:0]   count_q;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = count_q == (EvqPtrBits + 1)'(EvqDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/rsed_back.sv =====
// ----------------------------------------------------------------------------
// rsed_back: statistics stage and result buffer
// Takes glitch events, updates the saturating count, min, max and sum of
// sizes, and holds finished results in a two-entry buffer.
// ----------------------------------------------------------------------------
module rsed_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsed_pkg::event_t  ev_i,
  input  logic              ev_empty_i,
  output logic              ev_pop_o,
  input  rsed_pkg::qpop_t   res_ctl_i,
  output logic              res_empty_o,
  output rsed_pkg::result_t res_o
);
  import rsed_pkg::*;

  localparam logic [SumBits-1:0]   SumMax   = '1;
  localparam logic [CountBits-1:0] CountMax = '1;

  logic [CountBits-1:0] count_q;
  logic [SizeBits-1:0]  min_q;
  logic [SizeBits-1:0]  max_q;
  logic [SumBits-1:0]   sum_q;
  logic [CountBits-1:0] count_d;
  logic [SizeBits-1:0]  min_d;
  logic [SizeBits-1:0]  max_d;
  logic [SumBits-1:0]   sum_d;
  logic [SumBits-1:0]   size_ext;

  result_t                slot_q [ObufDepth];
  logic [ObufPtrBits-1:0] wr_ptr_q;
  logic [ObufPtrBits-1:0] rd_ptr_q;
  logic [ObufPtrBits:0]   fill_q;
  logic                   obuf_full;
  logic                   take;
  logic                   drop;
  result_t                res_new;

  assign obuf_full   = fill_q == (ObufPtrBits + 1)'(ObufDepth);
  assign res_empty_o = fill_q == '0;
  assign take        = !ev_empty_i && !obuf_full;
  assign drop        = res_ctl_i.pop && !res_ctl_i.empty;
  assign ev_pop_o    = take;
  assign res_o       = slot_q[rd_ptr_q];

  // Update statistics for the head event
  always_comb begin
    size_ext = {{(SumBits - SizeBits){1'b0}}, ev_i.size};
    count_d  = (count_q == CountMax) ? count_q : count_q + 1'b1;
    min_d    = (ev_i.size < min_q) ? ev_i.size : min_q;
    max_d    = (ev_i.size > max_q) ? ev_i.size : max_q;
    sum_d    = (size_ext >= (SumMax - sum_q)) ? SumMax : sum_q + size_ext;
    res_new.start_time = ev_i.start_time;
    res_new.rise_time  = ev_i.rise_time;
    res_new.size       = ev_i.size;
    res_new.wait_time  = ev_i.wait_time;
    res_new.count      = count_d;
    res_new.size_min   = min_d;
    res_new.size_max   = max_d;
    res_new.size_sum   = sum_d;
  end

  // Hold running statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      sum_q   <= '0;
    end else if (take) begin
      count_q <= count_d;
      min_q   <= min_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
    end
  end

  // Store finished results
  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q[wr_ptr_q] <= res_new;
    end
  end

  // Advance result buffer pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (take) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (drop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({take, drop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== design/rise_step_event_detector.sv =====
// ----------------------------------------------------------------------------
// rise_step_event_detector: glitch finder for rising steps in a sample stream
// Finds rises in timestamped samples, reports each glitch after the first
// with its timing and running size statistics.
//
//   channel   handshake       payload
//   -------   -------------   ------------------------------------------
//   sample    push / full     sample_time_i, sample_value_i
//   result    empty / pop     glitch_start_time_o .. size_sum_o
//   config    cfg_we_i        cfg_wdata_i (min_glitch_size)
//
// One sample is taken every cycle while full is low. A glitch event is
// registered in the event queue, then its result with statistics in the
// result buffer. A four-entry event queue and a two-entry result buffer
// absorb stalls on pop; full rises once both are full. Reset is
// asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rise_step_event_detector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rsed_pkg::SizeBits-1:0]         cfg_wdata_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic [rsed_pkg::TimeBits-1:0]         sample_time_i,
  input  logic signed [rsed_pkg::ValueBits-1:0] sample_value_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [rsed_pkg::TimeBits-1:0]         glitch_start_time_o,
  output logic [rsed_pkg::TimeBits-1:0]         rise_time_o,
  output logic [rsed_pkg::SizeBits-1:0]         glitch_size_o,
  output logic [rsed_pkg::TimeBits-1:0]         wait_time_o,
  output logic [rsed_pkg::CountBits-1:0]        glitch_count_o,
  output logic [rsed_pkg::SizeBits-1:0]         size_min_o,
  output logic [rsed_pkg::SizeBits-1:0]         size_max_o,
  output logic [rsed_pkg::SumBits-1:0]          size_sum_o
);
  import rsed_pkg::*;

  logic    accept;
  logic    ev_push;
  event_t  ev_in;
  event_t  ev_head;
  logic    ev_empty;
  logic    ev_pop;
  qpop_t   res_ctl;
  result_t res;

  assign accept      = push && !full;
  assign res_ctl.pop = pop;
  assign res_ctl.empty = empty;

  // Classify samples
  rsed_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .sample_time_i  (sample_time_i),
    .sample_value_i (sample_value_i),
    .ev_push_o      (ev_push),
    .ev_o           (ev_in)
  );

  // Queue glitch events
  rsed_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_in),
    .full_o  (full),
    .pop_i   (ev_pop),
    .empty_o (ev_empty),
    .data_o  (ev_head)
  );

  // Update statistics and buffer results
  rsed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev_head),
    .ev_empty_i  (ev_empty),
    .ev_pop_o    (ev_pop),
    .res_ctl_i   (res_ctl),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign glitch_start_time_o = res.start_time;
  assign rise_time_o         = res.rise_time;
  assign glitch_size_o       = res.size;
  assign wait_time_o         = res.wait_time;
  assign glitch_count_o      = res.count;
  assign size_min_o          = res.size_min;
  assign size_max_o          = res.size_max;
  assign size_sum_o          = res.size_sum;

endmodule

// ===== design/rsed_chk.sv =====
// ----------------------------------------------------------------------------
// rsed_chk: port level checks for the rise step event detector
// Watches the result channel for held requests and consistent statistics.
// ----------------------------------------------------------------------------
module rsed_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           empty,
  input logic                           pop,
  input logic [rsed_pkg::SizeBits-1:0]  glitch_size_o,
  input logic [rsed_pkg::CountBits-1:0] glitch_count_o,
  input logic [rsed_pkg::SizeBits-1:0]  size_min_o,
  input logic [rsed_pkg::SizeBits-1:0]  size_max_o,
  input logic [rsed_pkg::SumBits-1:0]   size_sum_o
);
  import rsed_pkg::*;

  // Hold a waiting result until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(glitch_count_o) && $stable(size_sum_o)))
    else $error("result changed while stalled");

  // Count every reported glitch
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (glitch_count_o != '0))
    else $error("result with zero count");

  // Keep this size within the running bounds
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (size_min_o <= glitch_size_o && glitch_size_o <= size_max_o))
    else $error("size outside min and max");

  // Sum never falls below the largest size
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (size_sum_o >= {{(SumBits - SizeBits){1'b0}}, size_max_o}))
    else $error("sum below max");

  // Count never goes back between results
  a_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) |=> (empty || glitch_count_o >= $past(glitch_count_o)))
    else $error("count decreased");

endmodule

bind rise_step_event_detector rsed_chk u_rsed_chk (.*);
